### rtl/core/sird_pkg.sv
`default_nettype none

package sird_pkg;

    localparam int RADIX_W    = 5;
    localparam int DIGIT_W    = 4;
    localparam int CHAR_W     = 8;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int DIV_STEP   = 8;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

    localparam logic [RADIX_W-1:0]    BASE_LENGTH_RST  = 5'd10;
    localparam logic [CFG_DATA_W-1:0] SYMBOLS_LOW_RST  = 64'h3736_3534_3332_3130;
    localparam logic [CFG_DATA_W-1:0] SYMBOLS_HIGH_RST = 64'h0;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

    localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;

    typedef struct packed {
        logic               done;
        logic [DIGIT_W-1:0] rem;
    } div_status_t;

    function automatic logic [CHAR_W-1:0] symbol_of(
        input logic [CFG_DATA_W-1:0] sym_low,
        input logic [CFG_DATA_W-1:0] sym_high,
        input logic [DIGIT_W-1:0]    digit
    );
        logic [CFG_DATA_W-1:0] word;
        word = digit[3] ? sym_high : sym_low;
        return word[{digit[2:0], 3'b000} +: CHAR_W];
    endfunction

endpackage

`default_nettype wire

### rtl/core/sird_divider.sv
`default_nettype none

module sird_divider #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [VALUE_WIDTH-1:0]      dividend,
    input  wire logic [sird_pkg::RADIX_W-1:0] radix,
    output logic [VALUE_WIDTH-1:0]           quotient,
    output sird_pkg::div_status_t            status
);
    import sird_pkg::*;

    localparam int PASSES = (VALUE_WIDTH + DIV_STEP - 1) / DIV_STEP;
    localparam int PAD_W  = PASSES * DIV_STEP;
    localparam int PASS_W = $clog2(PASSES + 1);

    logic [PAD_W-1:0]   work_reg;
    logic [PAD_W-1:0]   work_next;
    logic [DIGIT_W-1:0] rem_reg;
    logic [DIGIT_W-1:0] rem_next;
    logic [PASS_W-1:0]  pass_reg;
    logic               active_reg;
    logic               done_reg;

    // restoring division, DIV_STEP quotient bits per cycle
    always_comb
    begin
        logic [RADIX_W-1:0] t;
        work_next = work_reg;
        rem_next  = rem_reg;
        for (int k = 0; k < DIV_STEP; k++)
        begin
            t = {rem_next, work_next[PAD_W-1]};
            work_next = {work_next[PAD_W-2:0], 1'b0};
            if (t >= radix)
            begin
                t = t - radix;
                work_next[0] = 1'b1;
            end
            rem_next = t[DIGIT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_reg   <= '0;
            rem_reg    <= '0;
            pass_reg   <= '0;
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                work_reg   <= PAD_W'(dividend);
                rem_reg    <= '0;
                pass_reg   <= '0;
                active_reg <= 1'b1;
            end
            else if (active_reg)
            begin
                work_reg <= work_next;
                rem_reg  <= rem_next;
                pass_reg <= pass_reg + PASS_W'(1);
                if (pass_reg == PASS_W'(PASSES - 1))
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    assign quotient    = work_reg[VALUE_WIDTH-1:0];
    assign status.done = done_reg;
    assign status.rem  = rem_reg;

endmodule

`default_nettype wire

### rtl/core/signed_int_to_radix_digits.sv
// flow: the magnitude is divided by the radix again and again, one digit per divider run,
//   D = digit count; per digit one divider load and ceil(VALUE_WIDTH / 8) passes, then out
// throughput: a new transaction is accepted only while idle (busy low); a zero value
//   skips the divider, a minus sign comes from the prep state, the divider gives 8 quotient bits a cycle
// reset: asynchronous active low, control and config registers return to their defaults, block idle
// the receiver cannot stall: each character is shown for exactly one cycle
`default_nettype none

module signed_int_to_radix_digits #(
    parameter int VALUE_WIDTH = 32,
    parameter int MAX_DIGITS  = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_write,
    input  wire logic [sird_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [sird_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic signed [VALUE_WIDTH-1:0]      value,
    output logic                                    char_valid,
    output logic [sird_pkg::CHAR_W-1:0]             char_out,
    output logic                                    last_char
);
    import sird_pkg::*;

    localparam int ADDR_W = $clog2(MAX_DIGITS);
    localparam int CNT_W  = $clog2(MAX_DIGITS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIVIDE,
        S_PREP,
        S_EMIT
    } state_t;

    state_t                state_reg;
    logic [RADIX_W-1:0]    base_length_reg;
    logic [CFG_DATA_W-1:0] symbols_low_reg;
    logic [CFG_DATA_W-1:0] symbols_high_reg;
    logic [RADIX_W-1:0]    radix_reg;
    logic                  negative_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [ADDR_W-1:0]     emit_idx_reg;
    logic                  char_valid_reg;
    logic [CHAR_W-1:0]     char_out_reg;
    logic                  last_char_reg;

    logic [DIGIT_W-1:0]    digit_mem [MAX_DIGITS];
    logic [DIGIT_W-1:0]    digit_reg;

    logic [VALUE_WIDTH-1:0] value_u;
    logic                   value_neg;
    logic [VALUE_WIDTH-1:0] magnitude;
    logic [RADIX_W-1:0]     radix_now;
    logic                   accept;
    logic                   div_start;
    logic [VALUE_WIDTH-1:0] dividend;
    logic [VALUE_WIDTH-1:0] quotient;
    div_status_t            div_status;
    logic                   more_digits;
    logic [CNT_W-1:0]       count_m1;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [DIGIT_W-1:0]     mem_wdata;
    logic [ADDR_W-1:0]      mem_raddr;

    assign value_u   = $unsigned(value);
    assign value_neg = value_u[VALUE_WIDTH-1];
    assign magnitude = value_neg ? (~value_u + VALUE_WIDTH'(1)) : value_u;

    always_comb
    begin
        priority if (base_length_reg < RADIX_MIN)
            radix_now = RADIX_MIN;
        else if (base_length_reg > RADIX_MAX)
            radix_now = RADIX_MAX;
        else
            radix_now = base_length_reg;
    end

    assign accept      = start && (state_reg == S_IDLE);
    assign more_digits = (quotient != '0) && ((count_reg + CNT_W'(1)) != CNT_W'(MAX_DIGITS));
    assign div_start   = (accept && (magnitude != '0))
                       || ((state_reg == S_DIVIDE) && div_status.done && more_digits);
    assign dividend    = (state_reg == S_IDLE) ? magnitude : quotient;
    assign count_m1    = count_reg - CNT_W'(1);

    sird_divider #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_divider (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(dividend),
        .radix   (radix_reg),
        .quotient(quotient),
        .status  (div_status)
    );

    // zero value writes its single digit straight away
    assign mem_we    = (accept && (magnitude == '0))
                     || ((state_reg == S_DIVIDE) && div_status.done);
    assign mem_waddr = (state_reg == S_IDLE) ? '0 : count_reg[ADDR_W-1:0];
    assign mem_wdata = (state_reg == S_IDLE) ? '0 : div_status.rem;
    assign mem_raddr = (state_reg == S_PREP) ? count_m1[ADDR_W-1:0]
                                             : (emit_idx_reg - ADDR_W'(1));

    always_ff @(posedge clk)
    begin
        if (mem_we)
            digit_mem[mem_waddr] <= mem_wdata;
        digit_reg <= digit_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_length_reg  <= BASE_LENGTH_RST;
            symbols_low_reg  <= SYMBOLS_LOW_RST;
            symbols_high_reg <= SYMBOLS_HIGH_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_BASE_LENGTH:  base_length_reg  <= cfg_data[RADIX_W-1:0];
                REG_SYMBOLS_LOW:  symbols_low_reg  <= cfg_data;
                REG_SYMBOLS_HIGH: symbols_high_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            radix_reg      <= RADIX_MIN;
            negative_reg   <= 1'b0;
            count_reg      <= '0;
            emit_idx_reg   <= '0;
            char_valid_reg <= 1'b0;
            char_out_reg   <= '0;
            last_char_reg  <= 1'b0;
        end
        else
        begin
            char_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        radix_reg    <= radix_now;
                        negative_reg <= value_neg;
                        if (magnitude == '0)
                        begin
                            count_reg <= CNT_W'(1);
                            state_reg <= S_PREP;
                        end
                        else
                        begin
                            count_reg <= '0;
                            state_reg <= S_DIVIDE;
                        end
                    end
                end
                S_DIVIDE:
                begin
                    if (div_status.done)
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                        if (!more_digits)
                            state_reg <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    emit_idx_reg <= count_m1[ADDR_W-1:0];
                    if (negative_reg)
                    begin
                        char_valid_reg <= 1'b1;
                        char_out_reg   <= MINUS_CHAR;
                        last_char_reg  <= 1'b0;
                    end
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    char_valid_reg <= 1'b1;
                    char_out_reg   <= symbol_of(symbols_low_reg, symbols_high_reg, digit_reg);
                    last_char_reg  <= (emit_idx_reg == '0);
                    if (emit_idx_reg == '0)
                        state_reg <= S_IDLE;
                    else
                        emit_idx_reg <= emit_idx_reg - ADDR_W'(1);
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign char_valid = char_valid_reg;
    assign char_out   = char_out_reg;
    assign last_char  = last_char_reg;

endmodule

`default_nettype wire

### rtl/core/sird_checker.sv
`default_nettype none

module sird_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic char_valid,
    input wire logic last_char
);

    // an accepted transaction keeps the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accept");

    // only the final character may appear once the block is idle
    a_mid_char_busy: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && !last_char |-> busy)
        else $error("non-final character while idle");

    // the block goes idle exactly with the final character
    a_idle_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> char_valid && last_char)
        else $error("busy dropped without final character");

    // a final character is never followed directly by another
    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && last_char |=> !char_valid)
        else $error("character right after final character");

endmodule

bind signed_int_to_radix_digits sird_checker u_sird_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .char_valid(char_valid),
    .last_char (last_char)
);

`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import sird_pkg::*;

    localparam int VALUE_W     = 32;
    localparam int DIGITS_MAX  = 32;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 8;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam logic [CFG_DATA_W-1:0] ASCII_LOW  = 64'h3736_3534_3332_3130;
    localparam logic [CFG_DATA_W-1:0] ASCII_HIGH = 64'h6665_6463_6261_3938;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } text_char_t;

    logic                       clk        = 1'b0;
    logic                       rst_n      = 1'b0;
    logic                       cfg_write  = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index  = '0;
    logic [CFG_DATA_W-1:0]      cfg_data   = '0;
    logic                       start      = 1'b0;
    logic signed [VALUE_W-1:0]  value      = '0;
    logic                       busy;
    logic                       char_valid;
    logic [CHAR_W-1:0]          char_out;
    logic                       last_char;

    // predictor copy of the register file
    logic [RADIX_W-1:0]         radix_reg  = BASE_LENGTH_RST;
    logic [CFG_DATA_W-1:0]      glyphs_lo  = SYMBOLS_LOW_RST;
    logic [CFG_DATA_W-1:0]      glyphs_hi  = SYMBOLS_HIGH_RST;

    logic signed [VALUE_W-1:0]  pending_values[$];
    text_char_t                 expected_text[$];
    text_char_t                 want;

    logic                       took_item  = 1'b0;
    logic                       quiet_tail = 1'b0;
    int                         idle_left  = 0;
    int                         error_count = 0;
    int                         cycle_count = 0;

    signed_int_to_radix_digits #(
        .VALUE_WIDTH(VALUE_W),
        .MAX_DIGITS (DIGITS_MAX)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .start     (start),
        .busy      (busy),
        .value     (value),
        .char_valid(char_valid),
        .char_out  (char_out),
        .last_char (last_char)
    );

    always #2 clk = ~clk;

    // expected text of one number under the current register settings
    task automatic predict_text(input logic signed [VALUE_W-1:0] v);
        logic [VALUE_W:0]       mag;
        logic [RADIX_W-1:0]     radix;
        logic [DIGIT_W-1:0]     digits [DIGITS_MAX];
        logic [2*CFG_DATA_W-1:0] glyphs;
        int unsigned            count;
        radix  = radix_reg;
        if (radix < 5'd2)
            radix = 5'd2;
        else if (radix > 5'd16)
            radix = 5'd16;
        glyphs = {glyphs_hi, glyphs_lo};
        mag    = v[VALUE_W-1] ? ({(VALUE_W+1){1'b0}} - {v[VALUE_W-1], v}) : {1'b0, v};
        count  = 0;
        if (mag == '0)
        begin
            digits[0] = '0;
            count = 1;
        end
        else
        begin
            while (mag != '0 && count < DIGITS_MAX)
            begin
                digits[count] = DIGIT_W'(mag % radix);
                mag = mag / radix;
                count++;
            end
        end
        if (v[VALUE_W-1])
            expected_text.push_back('{ch: MINUS_CHAR, last: 1'b0});
        for (int unsigned i = count; i > 0; i--)
            expected_text.push_back('{ch: glyphs[digits[i-1]*8 +: 8], last: (i == 1)});
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        cfg_data  <= {$urandom, $urandom};
        case (idx)
            REG_BASE_LENGTH:  radix_reg = data[RADIX_W-1:0];
            REG_SYMBOLS_LOW:  glyphs_lo = data;
            REG_SYMBOLS_HIGH: glyphs_hi = data;
            default: ;
        endcase
    endtask

    task automatic set_base(input logic [RADIX_W-1:0] b);
        logic [CFG_DATA_W-1:0] word;
        word = {$urandom, $urandom};
        word[RADIX_W-1:0] = b;
        write_reg(REG_BASE_LENGTH, word);
    endtask

    // wait until every queued transaction is taken and its text has come out
    task automatic drain();
        do
            @(posedge clk);
        while (pending_values.size() != 0 || start);
        @(negedge clk);
        while (expected_text.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    function automatic logic signed [VALUE_W-1:0] random_value();
        logic signed [VALUE_W-1:0] v;
        case ($urandom_range(0, 4))
            0, 1: v = $urandom;
            2:    v = $urandom_range(0, 40);
            3:    v = $urandom >> $urandom_range(0, 31);
            default:
            begin
                v = $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7fff_ffff;
                if ($urandom_range(0, 2) == 0)
                    v = $urandom_range(0, 1) ? 32'sh0 : -32'sh1;
            end
        endcase
        if ($urandom_range(0, 1))
            v = -v;
        return v;
    endfunction

    // driver
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (!start || took_item)
        begin
            if (idle_left > 0)
            begin
                idle_left--;
                start <= 1'b0;
                value <= $urandom;
            end
            else if (pending_values.size() != 0 && !quiet_tail && $urandom_range(0, 4) == 0)
            begin
                idle_left = $urandom_range(1, 17) - 1;
                start <= 1'b0;
                value <= $urandom;
            end
            else if (pending_values.size() != 0)
            begin
                start <= 1'b1;
                value <= pending_values.pop_front();
            end
            else
            begin
                start <= 1'b0;
                value <= $urandom;
            end
        end
    end

    // monitor and checker
    always @(posedge clk)
    begin
        took_item <= rst_n && start && !busy;
        if (rst_n)
        begin
            if (char_valid)
            begin
                if (expected_text.size() == 0)
                begin
                    $error("unexpected transaction: char_out %h last_char %b", char_out, last_char);
                    error_count++;
                end
                else
                begin
                    want = expected_text.pop_front();
                    if (char_out !== want.ch)
                    begin
                        $error("char_out mismatch: expected %h, actual %h", want.ch, char_out);
                        error_count++;
                    end
                    if (last_char !== want.last)
                    begin
                        $error("last_char mismatch: expected %b, actual %b", want.last, last_char);
                        error_count++;
                    end
                end
            end
            if (start && !busy)
                predict_text(value);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        logic [CFG_DATA_W-1:0] word;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        drain();

        // reset settings: base ten, digits 8 and 9 map to a zero byte
        pending_values = '{32'sh0, 32'sh1, -32'sh1, 32'sh9, 32'sh59,
                           32'sh7fff_ffff, 32'sh8000_0000, -32'sh0a};
        drain();

        set_base(5'd16);
        write_reg(REG_SYMBOLS_LOW, ASCII_LOW);
        write_reg(REG_SYMBOLS_HIGH, ASCII_HIGH);
        pending_values = '{32'sh0, -32'sh1, 32'sh7fff_ffff, 32'sh8000_0000, 32'shff, -32'sh100};
        drain();

        // most negative value in base two gives the longest text
        set_base(5'd2);
        pending_values = '{32'sh8000_0000, -32'sh1, 32'sh7fff_ffff, 32'sh5};
        drain();

        // radix out of range on both sides, and a write to an unused index
        set_base(5'd0);
        pending_values = '{-32'sh6};
        drain();
        set_base(5'd1);
        write_reg(REG_SPARE, {$urandom, $urandom});
        pending_values = '{32'sh7};
        drain();
        set_base(5'd17);
        pending_values = '{32'sh1234_abcd};
        drain();
        set_base(5'd31);
        pending_values = '{32'sh8000_0000, 32'sh0};
        drain();

        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0:       set_base(5'd2);
                1:       set_base(5'd16);
                default: set_base($urandom_range(0, 31));
            endcase
            if ($urandom_range(0, 1))
            begin
                write_reg(REG_SYMBOLS_LOW, ASCII_LOW);
                write_reg(REG_SYMBOLS_HIGH, ASCII_HIGH);
            end
            else
            begin
                word = {$urandom, $urandom};
                write_reg(REG_SYMBOLS_LOW, word);
                word = {$urandom, $urandom};
                write_reg(REG_SYMBOLS_HIGH, word);
            end
            if (p == 3)
                write_reg(REG_SPARE, {$urandom, $urandom});
            quiet_tail = (p == 7);
            repeat (17)
                pending_values.push_back(random_value());
            drain();
        end

        repeat (200) @(negedge clk);
        if (error_count == 0 && expected_text.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
